// ===== src/ms_pkg.sv =====
// Package for the merge sorter: sizes, transfer payload types and the cell
// control struct. Used by ms_cell and merge_sorter; depends on nothing.
package ms_pkg;

  localparam int MaxElements = 64;
  localparam int ValueBits   = 32;

  typedef struct packed {
    logic signed [ValueBits-1:0] value;
    logic                        final_item;
  } in_item_t;

  typedef struct packed {
    logic signed [ValueBits-1:0] sorted_value;
    logic                        final_result;
    logic                        overflowed;
  } out_item_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic insert;     // place the broadcast value into the sorted row
    logic shift_out;  // move every entry one place toward the head
  } cell_ctrl_t;

endpackage

// ===== src/ms_cell.sv =====
// One cell of the sorting chain: holds one value and its valid bit.
// Depends on ms_pkg.
module ms_cell (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  ms_pkg::cell_ctrl_t                   ctrl_i,
  input  logic signed [ms_pkg::ValueBits-1:0]  new_val_i,
  input  logic signed [ms_pkg::ValueBits-1:0]  left_val_i,
  input  logic                                 left_take_i,
  input  logic                                 left_vld_i,
  input  logic signed [ms_pkg::ValueBits-1:0]  right_val_i,
  input  logic                                 right_vld_i,
  output logic signed [ms_pkg::ValueBits-1:0]  val_o,
  output logic                                 vld_o,
  output logic                                 take_o
);

  logic signed [ms_pkg::ValueBits-1:0] val_q, val_d;
  logic                                vld_q, vld_d;

  // Strictly smaller goes in front, so equal values keep arrival order.
  assign take_o = !vld_q || (new_val_i < val_q);

  always_comb begin
    val_d = val_q;
    vld_d = vld_q;
    if (ctrl_i.shift_out) begin
      val_d = right_val_i;
      vld_d = right_vld_i;
    end else if (ctrl_i.insert) begin
      if (take_o) begin
        // the left neighbor also taking means its old entry slides in here
        val_d = left_take_i ? left_val_i : new_val_i;
      end
      vld_d = vld_q | left_vld_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;
  assign vld_o = vld_q;

endmodule

// ===== src/merge_sorter.sv =====
// Top level of the sorter: chain of ms_cell insertion cells plus emit control.
// Depends on ms_pkg and ms_cell.
//
// Each accepted item is placed in sorted position in the same cycle it is
// transferred, so a new item can be loaded every cycle while busy is low.
// The transfer flagged final_item starts output: busy is high while the n
// stored values leave the head of the cell chain, one per cycle, smallest
// first. Results cannot be held off; the receiver must take every cycle in
// which result_valid_o is high.
// Items beyond the chain length are dropped and flagged on the last result.
module merge_sorter (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  ms_pkg::in_item_t  in_i,
  output logic              busy,
  output logic              result_valid_o,
  output ms_pkg::out_item_t result_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StEmit = 1'b1;

  localparam int N = ms_pkg::MaxElements;

  logic [0:0] state_q, state_d;
  logic       ovf_q, ovf_d;

  logic signed [ms_pkg::ValueBits-1:0] cell_val  [N];
  logic [N-1:0]                        cell_vld;
  logic [N-1:0]                        cell_take;
  ms_pkg::cell_ctrl_t                  ctrl;
  logic                                accept;
  logic                                full;

  assign busy   = (state_q == StEmit);
  assign accept = start && !busy;
  assign full   = cell_vld[N-1];

  assign ctrl.insert    = accept && !full;
  assign ctrl.shift_out = busy;

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic signed [ms_pkg::ValueBits-1:0] l_val, r_val;
    logic                                l_take, l_vld, r_vld;
    if (i == 0) begin : g_head
      assign l_val  = '0;
      assign l_take = 1'b0;
      assign l_vld  = 1'b1;
    end else begin : g_mid
      assign l_val  = cell_val[i-1];
      assign l_take = cell_take[i-1];
      assign l_vld  = cell_vld[i-1];
    end
    if (i == N-1) begin : g_tail
      assign r_val = '0;
      assign r_vld = 1'b0;
    end else begin : g_body
      assign r_val = cell_val[i+1];
      assign r_vld = cell_vld[i+1];
    end
    ms_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .new_val_i   (in_i.value),
      .left_val_i  (l_val),
      .left_take_i (l_take),
      .left_vld_i  (l_vld),
      .right_val_i (r_val),
      .right_vld_i (r_vld),
      .val_o       (cell_val[i]),
      .vld_o       (cell_vld[i]),
      .take_o      (cell_take[i])
    );
  end

  always_comb begin
    state_d = state_q;
    ovf_d   = ovf_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          if (full) begin
            ovf_d = 1'b1;
          end
          if (in_i.final_item) begin
            state_d = StEmit;
          end
        end
      end
      StEmit: begin
        // head holds the last value once the next cell is empty
        if (!cell_vld[1]) begin
          state_d = StIdle;
          ovf_d   = 1'b0;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      ovf_q   <= ovf_d;
    end
  end

  assign result_valid_o        = busy && cell_vld[0];
  assign result_o.sorted_value = cell_val[0];
  assign result_o.final_result = !cell_vld[1];
  assign result_o.overflowed   = !cell_vld[1] && ovf_q;

endmodule
